// ===== hdl/cdc1d_pkg.sv =====
`default_nettype none
package cdc1d_pkg;

    typedef enum logic [1:0] {
        ACT_WEIGHT = 2'd0,
        ACT_BIAS   = 2'd1,
        ACT_SAMPLE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    localparam logic [1:0] REG_IN_CH  = 2'd0;
    localparam logic [1:0] REG_OUT_CH = 2'd1;
    localparam logic [1:0] REG_TAPS   = 2'd2;
    localparam logic [1:0] REG_DIL    = 2'd3;

    localparam int RESULT_CAP = 16;
    localparam int ACC_W      = 64;
    localparam int RES_W      = 40;

endpackage
`default_nettype wire

// ===== hdl/causal_dilated_conv1d_core.sv =====
`default_nettype none
// Channel  | Direction | Handshake         | Payload
// s_axis   | in        | s_tvalid/s_tready | tdata: action, out_index, in_index, tap_index,
//          |           |                   |        sample_or_weight, bias_word
// m_axis   | out       | m_tvalid/m_tready | tdata: out_channel, conv_result; tlast: last_of_step
// apb      | in        | psel/penable      | four 32-bit registers at 4*i
//
// A load, clear, or non-final sample request is taken in ST_IDLE, which it does not leave. A final
// sample of a time step starts the sequencer: for each used output channel it reads the bias,
// then one weight/history pair per cycle from the two memories, feeding one registered
// multiplier and an accumulator; the result then waits in the output register. The single
// memory read port of each store sets that pair rate.
// Reset (aresetn low, synchronous) clears the pointer, step count and control and sets the
// configuration registers to 1; stores are undefined until written. A stall on m_tready
// holds the sequencer.
module causal_dilated_conv1d_core #(
    parameter int MAX_IN_CH  = 8,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_TAPS   = 8,
    parameter int HIST_DEPTH = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [1:0] action, [5:2] out_index, [8:6] in_index, [11:9] tap_index,
    // [27:12] sample_or_weight, [59:28] bias_word, [63:60] zero
    input  wire  [63:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [3:0] out_channel, [43:4] conv_result, [47:44] zero
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
    localparam int OW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int KW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int HW = $clog2(HIST_DEPTH);
    localparam int SW = $clog2(HIST_DEPTH + 1);
    localparam int LW = KW + 4 + 1;
    localparam int NOUT_MAX = (MAX_OUT_CH < cdc1d_pkg::RESULT_CAP) ?
                              MAX_OUT_CH : cdc1d_pkg::RESULT_CAP;

    // Configuration registers.
    logic [3:0] in_ch_reg, taps_reg, dil_reg;
    logic [4:0] out_ch_reg;
    logic       cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ch_reg  <= 4'd1;
            out_ch_reg <= 5'd1;
            taps_reg   <= 4'd1;
            dil_reg    <= 4'd1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                cdc1d_pkg::REG_IN_CH:  in_ch_reg  <= pwdata[3:0];
                cdc1d_pkg::REG_OUT_CH: out_ch_reg <= pwdata[4:0];
                cdc1d_pkg::REG_TAPS:   taps_reg   <= pwdata[3:0];
                cdc1d_pkg::REG_DIL:    dil_reg    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            cdc1d_pkg::REG_IN_CH:  prdata = {28'd0, in_ch_reg};
            cdc1d_pkg::REG_OUT_CH: prdata = {27'd0, out_ch_reg};
            cdc1d_pkg::REG_TAPS:   prdata = {28'd0, taps_reg};
            default:               prdata = {28'd0, dil_reg};
        endcase
    end

    // Effective (clamped) counts, held narrow.
    logic [6:0] nin, nout, ntap;
    logic [3:0] dil;
    always_comb begin
        nin  = (in_ch_reg == 4'd0) ? 7'd1 :
               ({3'd0, in_ch_reg} > 7'(MAX_IN_CH)) ? 7'(MAX_IN_CH) : {3'd0, in_ch_reg};
        nout = (out_ch_reg == 5'd0) ? 7'd1 :
               ({2'd0, out_ch_reg} > 7'(NOUT_MAX)) ? 7'(NOUT_MAX) : {2'd0, out_ch_reg};
        ntap = (taps_reg == 4'd0) ? 7'd1 :
               ({3'd0, taps_reg} > 7'(MAX_TAPS)) ? 7'(MAX_TAPS) : {3'd0, taps_reg};
        dil  = (dil_reg == 4'd0) ? 4'd1 : dil_reg;
    end

    // Input fields.
    logic [1:0]         f_act;
    logic [3:0]         f_oi;
    logic [2:0]         f_ii, f_ki;
    logic signed [15:0] f_sw;
    logic signed [31:0] f_bw;
    assign f_act = s_tdata[1:0];
    assign f_oi  = s_tdata[5:2];
    assign f_ii  = s_tdata[8:6];
    assign f_ki  = s_tdata[11:9];
    assign f_sw  = s_tdata[27:12];
    assign f_bw  = s_tdata[59:28];

    // Memories.
    logic signed [15:0] wmem [MAX_OUT_CH*MAX_IN_CH*MAX_TAPS];
    logic signed [31:0] bmem [MAX_OUT_CH];
    logic signed [15:0] hmem [MAX_IN_CH*HIST_DEPTH];
    localparam int WAW = OW + IW + KW;
    localparam int HAW = IW + HW;

    cdc1d_pkg::state_t state_reg, state_next;
    logic [HW-1:0] tp_reg;
    logic [SW-1:0] seen_reg;
    logic [OW-1:0] o_reg;
    logic [IW-1:0] i_reg;
    logic [KW-1:0] k_reg;
    logic          rd_v_reg, mul_v_reg, use_reg, rd_use_reg;
    logic          issue_done_reg;
    logic signed [15:0] w_q_reg, h_q_reg;
    logic signed [31:0] b_q_reg, prod_reg;
    logic signed [cdc1d_pkg::ACC_W-1:0] acc_reg;
    logic [cdc1d_pkg::RES_W-1:0] res_reg;
    logic [3:0] res_ch_reg;
    logic       res_last_reg, out_v_reg;

    logic s_acc;
    assign s_tready = (state_reg == cdc1d_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    logic fire;
    assign fire = s_acc && (f_act == cdc1d_pkg::ACT_SAMPLE) &&
                  (32'(f_ii) < MAX_IN_CH) && ({4'd0, f_ii} == nin - 7'd1);

    // Sequencer counters: one tap read per cycle in ST_RUN.
    logic last_k, last_i, last_o;
    assign last_k = ({2'd0, k_reg} == 7'(ntap - 7'd1));
    assign last_i = ({1'b0, i_reg} == 7'(nin - 7'd1)) || (IW >= 7);
    assign last_o = ({1'b0, o_reg} == 7'(nout - 7'd1));

    // Lag of current tap: (ntap-1-k)*dil; tap valid if below steps seen and depth.
    logic [LW-1:0] lag;
    logic          tap_ok;
    logic [HW-1:0] hpos;
    always_comb begin
        lag    = LW'((ntap - 7'd1 - {2'd0, k_reg}) * dil);
        tap_ok = (32'(lag) < 32'(seen_reg)) && (32'(lag) < HIST_DEPTH);
        hpos   = HW'(32'(tp_reg) + HIST_DEPTH - 32'(lag));
        if (32'(tp_reg) + HIST_DEPTH - 32'(lag) >= HIST_DEPTH)
            hpos = HW'(32'(tp_reg) - 32'(lag));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cdc1d_pkg::ST_IDLE:  if (fire) state_next = cdc1d_pkg::ST_BIAS;
            cdc1d_pkg::ST_BIAS:  state_next = cdc1d_pkg::ST_RUN;
            cdc1d_pkg::ST_RUN:   if (last_k && last_i) state_next = cdc1d_pkg::ST_DRAIN;
            cdc1d_pkg::ST_DRAIN: if (!rd_v_reg && !mul_v_reg) state_next = cdc1d_pkg::ST_EMIT;
            cdc1d_pkg::ST_EMIT:  if (!out_v_reg || m_tready)
                state_next = last_o ? cdc1d_pkg::ST_IDLE : cdc1d_pkg::ST_BIAS;
            default: state_next = cdc1d_pkg::ST_IDLE;
        endcase
    end

    logic signed [cdc1d_pkg::ACC_W-1:0] sat_hi, sat_lo;
    assign sat_hi = (64'sd1 <<< (cdc1d_pkg::RES_W - 1)) - 64'sd1;
    assign sat_lo = -(64'sd1 <<< (cdc1d_pkg::RES_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cdc1d_pkg::ST_IDLE;
            tp_reg    <= '0;
            seen_reg  <= '0;
            o_reg <= '0; i_reg <= '0; k_reg <= '0;
            rd_v_reg <= 1'b0; mul_v_reg <= 1'b0; out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            rd_v_reg  <= (state_reg == cdc1d_pkg::ST_RUN);
            mul_v_reg <= rd_v_reg;
            if (s_acc && f_act == cdc1d_pkg::ACT_CLEAR) begin
                tp_reg <= '0; seen_reg <= '0;
            end
            if (fire) begin
                if (32'(seen_reg) < HIST_DEPTH) seen_reg <= seen_reg + SW'(1);
                o_reg <= '0;
            end
            if (state_reg == cdc1d_pkg::ST_BIAS) begin
                i_reg <= '0; k_reg <= '0;
            end
            if (state_reg == cdc1d_pkg::ST_RUN) begin
                if (last_k) begin
                    k_reg <= '0; i_reg <= i_reg + IW'(1);
                end else k_reg <= k_reg + KW'(1);
            end
            if (state_reg == cdc1d_pkg::ST_EMIT && (!out_v_reg || m_tready)) begin
                out_v_reg <= 1'b1;
                o_reg     <= o_reg + OW'(1);
                if (last_o) tp_reg <= HW'((32'(tp_reg) + 1) % HIST_DEPTH);
            end
        end
    end

    // Memory ports and datapath.
    always_ff @(posedge aclk) begin
        if (s_acc && f_act == cdc1d_pkg::ACT_WEIGHT && 32'(f_oi) < MAX_OUT_CH &&
            32'(f_ii) < MAX_IN_CH && 32'(f_ki) < MAX_TAPS)
            wmem[WAW'((32'(f_oi) * MAX_IN_CH + 32'(f_ii)) * MAX_TAPS + 32'(f_ki))] <= f_sw;
        if (s_acc && f_act == cdc1d_pkg::ACT_BIAS && 32'(f_oi) < MAX_OUT_CH)
            bmem[OW'(f_oi)] <= f_bw;
        if (s_acc && f_act == cdc1d_pkg::ACT_SAMPLE && 32'(f_ii) < MAX_IN_CH)
            hmem[HAW'(32'(f_ii) * HIST_DEPTH + 32'(tp_reg))] <= f_sw;
        w_q_reg <= wmem[WAW'((32'(o_reg) * MAX_IN_CH + 32'(i_reg)) * MAX_TAPS + 32'(k_reg))];
        h_q_reg <= hmem[HAW'(32'(i_reg) * HIST_DEPTH + 32'(hpos))];
        b_q_reg <= bmem[o_reg];
        rd_use_reg <= tap_ok;
        use_reg    <= rd_use_reg;
        prod_reg   <= rd_use_reg ? 32'(w_q_reg * h_q_reg) : 32'sd0;
        if (state_reg == cdc1d_pkg::ST_RUN && i_reg == '0 && k_reg == '0)
            acc_reg <= 64'(b_q_reg);
        else if (mul_v_reg)
            acc_reg <= acc_reg + 64'(prod_reg);
        if (state_reg == cdc1d_pkg::ST_EMIT && (!out_v_reg || m_tready)) begin
            res_reg <= (acc_reg > sat_hi) ? sat_hi[cdc1d_pkg::RES_W-1:0] :
                       (acc_reg < sat_lo) ? sat_lo[cdc1d_pkg::RES_W-1:0] :
                       acc_reg[cdc1d_pkg::RES_W-1:0];
            res_ch_reg   <= 4'(o_reg);
            res_last_reg <= last_o;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {4'd0, res_reg, res_ch_reg};
    assign m_tlast  = res_last_reg;

    // Input is refused while a time step is being computed.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != cdc1d_pkg::ST_IDLE) |-> !s_tready) else $error("accept while busy");
    // A held result is never overwritten.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result lost");
    // A step start always leads into the bias fetch.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (state_reg == cdc1d_pkg::ST_BIAS)) else $error("no step start");
endmodule
`default_nettype wire
